// ===== hw/rtl/psd_pkg.sv =====
// Shared definitions for the per-pixel standard deviation block.
// Holds constants, opcodes, the controller state type and the command/status structs.
// No dependencies.
package psd_pkg;

    localparam int PIXELS      = 4096;
    localparam int ADDR_W      = $clog2(PIXELS);
    localparam int PC_W        = ADDR_W + 1;
    localparam int MAX_IMAGES  = 256;
    localparam int IMG_W       = $clog2(MAX_IMAGES) + 1;
    localparam int SAMPLE_W    = 16;
    localparam int SUM_W       = 24;
    localparam int SQ_W        = 40;
    localparam int SQ_HALF_W   = SQ_W / 2;
    localparam int MUL_W       = 24;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int NUM_W       = 48;
    localparam int DEN_W       = 16;
    localparam int QUO_W       = 64;
    localparam int ROOT_W      = QUO_W / 2;
    localparam int SD_W        = 24;
    localparam int STEP_W      = 6;
    localparam int DIV_STEPS   = QUO_W;
    localparam int SQRT_STEPS  = ROOT_W;

    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_READ  = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FEW     = 2'd1;
    localparam logic [1:0] ST_PARTIAL = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ACC,
        S_MUL_SQ,
        S_MUL_LO,
        S_MUL_HI,
        S_DIV_INIT,
        S_DIV,
        S_SQRT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic acc_start;
        logic read_start;
        logic clear;
        logic acc_write;
        logic mul_sq;
        logic mul_lo;
        logic mul_hi;
        logic div_init;
        logic div_step;
        logic sqrt_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic series_full;
        logic few_images;
        logic partial;
        logic out_free;
    } stat_t;

endpackage

// ===== hw/rtl/psd_ctrl.sv =====
// Controller state machine for the per-pixel standard deviation block.
// Depends on psd_pkg; drives commands into psd_datapath.
module psd_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [1:0]        action,
    output logic              in_stall,
    output psd_pkg::cmd_t     cmd,
    input  psd_pkg::stat_t    stat
);

    psd_pkg::state_t             state_reg;
    psd_pkg::state_t             state_next;
    logic [psd_pkg::STEP_W-1:0]  step_reg;
    logic [psd_pkg::STEP_W-1:0]  step_next;
    logic                        idle_valid;

    assign idle_valid = (state_reg == psd_pkg::S_IDLE) && in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= psd_pkg::S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            psd_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (psd_pkg::action_t'(action))
                        psd_pkg::ACT_ADD:
                        begin
                            if (!stat.series_full)
                            begin
                                state_next = psd_pkg::S_ACC;
                            end
                        end
                        psd_pkg::ACT_READ:
                        begin
                            if (stat.few_images || stat.partial)
                            begin
                                state_next = psd_pkg::S_DONE;
                            end
                            else
                            begin
                                state_next = psd_pkg::S_MUL_SQ;
                            end
                        end
                        default:
                        begin
                            state_next = psd_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            psd_pkg::S_ACC:      state_next = psd_pkg::S_IDLE;
            psd_pkg::S_MUL_SQ:   state_next = psd_pkg::S_MUL_LO;
            psd_pkg::S_MUL_LO:   state_next = psd_pkg::S_MUL_HI;
            psd_pkg::S_MUL_HI:   state_next = psd_pkg::S_DIV_INIT;
            psd_pkg::S_DIV_INIT: state_next = psd_pkg::S_DIV;
            psd_pkg::S_DIV:
            begin
                if (step_reg == psd_pkg::STEP_W'(psd_pkg::DIV_STEPS - 1))
                begin
                    state_next = psd_pkg::S_SQRT;
                end
            end
            psd_pkg::S_SQRT:
            begin
                if (step_reg == psd_pkg::STEP_W'(psd_pkg::SQRT_STEPS - 1))
                begin
                    state_next = psd_pkg::S_DONE;
                end
            end
            psd_pkg::S_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = psd_pkg::S_IDLE;
                end
            end
            default:     state_next = psd_pkg::S_IDLE;
        endcase
    end

    // The step counter restarts whenever the state changes.
    always_comb
    begin
        if (state_next != state_reg)
        begin
            step_next = '0;
        end
        else
        begin
            step_next = step_reg + 1'b1;
        end
    end

    // Outputs.
    always_comb
    begin
        in_stall       = (state_reg != psd_pkg::S_IDLE);
        cmd            = '0;
        cmd.acc_start  = idle_valid && (action == psd_pkg::ACT_ADD) && !stat.series_full;
        cmd.read_start = idle_valid && (action == psd_pkg::ACT_READ);
        cmd.clear      = idle_valid && (action == psd_pkg::ACT_CLEAR);
        cmd.acc_write  = (state_reg == psd_pkg::S_ACC);
        cmd.mul_sq     = (state_reg == psd_pkg::S_MUL_SQ);
        cmd.mul_lo     = (state_reg == psd_pkg::S_MUL_LO);
        cmd.mul_hi     = (state_reg == psd_pkg::S_MUL_HI);
        cmd.div_init   = (state_reg == psd_pkg::S_DIV_INIT);
        cmd.div_step   = (state_reg == psd_pkg::S_DIV);
        cmd.sqrt_step  = (state_reg == psd_pkg::S_SQRT);
        cmd.out_load   = (state_reg == psd_pkg::S_DONE) && stat.out_free;
    end

endmodule

// ===== hw/rtl/psd_datapath.sv =====
// Datapath for the per-pixel standard deviation block: stores, counters,
// shared multiplier, restoring divider, square root and output register.
// Depends on psd_pkg; controlled by psd_ctrl.
module psd_datapath
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  psd_pkg::cmd_t                   cmd,
    output psd_pkg::stat_t                  stat,
    input  logic [psd_pkg::SAMPLE_W-1:0]    sample,
    input  logic                            cfg_write_en,
    input  logic [psd_pkg::PC_W-1:0]        cfg_write_data,
    input  logic                            out_stall,
    output logic                            out_valid,
    output logic [psd_pkg::SD_W-1:0]        std_dev,
    output logic                            last_pixel,
    output logic [1:0]                      status
);

    localparam int A = psd_pkg::ADDR_W;
    localparam int P = psd_pkg::PC_W;

    logic [psd_pkg::SUM_W-1:0]    sum_mem [psd_pkg::PIXELS];
    logic [psd_pkg::SQ_W-1:0]     sq_mem  [psd_pkg::PIXELS];

    logic [P-1:0]                 pc_cfg_reg;
    logic [P-1:0]                 pc;
    logic [psd_pkg::IMG_W-1:0]    img_cnt_reg;
    logic [A-1:0]                 wp_reg;
    logic [A-1:0]                 rp_reg;

    logic [P-1:0]                 wp_inc;
    logic                         wp_wrap;
    logic [A-1:0]                 rd_pos;
    logic [P-1:0]                 rd_inc;
    logic                         rd_last;
    logic [A-1:0]                 mem_addr;

    logic [psd_pkg::SUM_W-1:0]    sum_rd_reg;
    logic [psd_pkg::SQ_W-1:0]     sq_rd_reg;
    logic [psd_pkg::SAMPLE_W-1:0] smp_reg;
    logic [2*psd_pkg::SAMPLE_W-1:0] smp_sq_reg;
    logic                         first_image;
    logic [psd_pkg::SUM_W-1:0]    sum_wr;
    logic [psd_pkg::SQ_W-1:0]     sq_wr;

    logic                         last_reg;
    logic [1:0]                   st_reg;

    logic [psd_pkg::MUL_W-1:0]    mul_a;
    logic [psd_pkg::MUL_W-1:0]    mul_b;
    logic [psd_pkg::PROD_W-1:0]   prod;
    logic [psd_pkg::NUM_W-1:0]    ssq_reg;
    logic [psd_pkg::NUM_W-1:0]    acc_reg;
    logic [psd_pkg::DEN_W-1:0]    den_reg;
    logic [2*psd_pkg::IMG_W-1:0]  den_full;
    logic [psd_pkg::NUM_W-1:0]    num;

    logic [psd_pkg::QUO_W-1:0]    quo_reg;
    logic [psd_pkg::DEN_W-1:0]    drem_reg;
    logic [psd_pkg::DEN_W:0]      dpart;
    logic                         dbit;

    logic [psd_pkg::ROOT_W-1:0]   root_reg;
    logic [psd_pkg::ROOT_W+1:0]   srem_reg;
    logic [psd_pkg::ROOT_W+2:0]   spart;
    logic [psd_pkg::ROOT_W+2:0]   strial;
    logic                         sbit;

    logic                         out_valid_reg;
    logic [psd_pkg::SD_W-1:0]     std_dev_reg;
    logic                         last_out_reg;
    logic [1:0]                   status_reg;
    logic [psd_pkg::SD_W-1:0]     sd_sat;

    // Effective pixel count: zero acts as one, anything above the store depth is clipped.
    always_comb
    begin
        if (pc_cfg_reg == '0)
        begin
            pc = P'(1);
        end
        else if (pc_cfg_reg > P'(psd_pkg::PIXELS))
        begin
            pc = P'(psd_pkg::PIXELS);
        end
        else
        begin
            pc = pc_cfg_reg;
        end
    end

    assign wp_inc   = {1'b0, wp_reg} + 1'b1;
    assign wp_wrap  = (wp_inc >= pc);
    assign rd_pos   = ({1'b0, rp_reg} >= pc) ? '0 : rp_reg;
    assign rd_inc   = {1'b0, rd_pos} + 1'b1;
    assign rd_last  = (rd_inc >= pc);
    assign mem_addr = cmd.read_start ? rd_pos : wp_reg;

    assign stat.series_full = (img_cnt_reg == psd_pkg::IMG_W'(psd_pkg::MAX_IMAGES));
    assign stat.few_images  = (img_cnt_reg < psd_pkg::IMG_W'(2));
    assign stat.partial     = (wp_reg != '0);
    assign stat.out_free    = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_cfg_reg  <= P'(psd_pkg::PIXELS);
            img_cnt_reg <= '0;
            wp_reg      <= '0;
            rp_reg      <= '0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                pc_cfg_reg <= cfg_write_data;
            end
            if (cmd.clear)
            begin
                img_cnt_reg <= '0;
                wp_reg      <= '0;
                rp_reg      <= '0;
            end
            else
            begin
                if (cmd.acc_write)
                begin
                    if (wp_wrap)
                    begin
                        wp_reg      <= '0;
                        img_cnt_reg <= img_cnt_reg + 1'b1;
                    end
                    else
                    begin
                        wp_reg <= wp_inc[A-1:0];
                    end
                end
                if (cmd.read_start)
                begin
                    rp_reg <= rd_last ? '0 : rd_inc[A-1:0];
                end
            end
        end
    end

    // Store access: one registered read and one write per cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.acc_start || cmd.read_start)
        begin
            sum_rd_reg <= sum_mem[mem_addr];
            sq_rd_reg  <= sq_mem[mem_addr];
        end
        if (cmd.acc_write)
        begin
            sum_mem[wp_reg] <= sum_wr;
            sq_mem[wp_reg]  <= sq_wr;
        end
    end

    assign first_image = (img_cnt_reg == '0);
    assign sum_wr = first_image ? psd_pkg::SUM_W'(smp_reg)
                                : sum_rd_reg + psd_pkg::SUM_W'(smp_reg);
    assign sq_wr  = first_image ? psd_pkg::SQ_W'(smp_sq_reg)
                                : sq_rd_reg + psd_pkg::SQ_W'(smp_sq_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.acc_start)
        begin
            smp_reg    <= sample;
            smp_sq_reg <= sample * sample;
        end
        if (cmd.read_start)
        begin
            last_reg <= rd_last;
            if (stat.few_images)
            begin
                st_reg <= psd_pkg::ST_FEW;
            end
            else if (stat.partial)
            begin
                st_reg <= psd_pkg::ST_PARTIAL;
            end
            else
            begin
                st_reg <= psd_pkg::ST_OK;
            end
        end
    end

    // Shared multiplier: S*S, then n times each half of the square sum.
    always_comb
    begin
        mul_a = sum_rd_reg;
        mul_b = sum_rd_reg;
        if (cmd.mul_lo)
        begin
            mul_a = psd_pkg::MUL_W'(img_cnt_reg);
            mul_b = psd_pkg::MUL_W'(sq_rd_reg[psd_pkg::SQ_HALF_W-1:0]);
        end
        else if (cmd.mul_hi)
        begin
            mul_a = psd_pkg::MUL_W'(img_cnt_reg);
            mul_b = psd_pkg::MUL_W'(sq_rd_reg[psd_pkg::SQ_W-1:psd_pkg::SQ_HALF_W]);
        end
    end

    assign prod     = mul_a * mul_b;
    assign den_full = img_cnt_reg * (img_cnt_reg - 1'b1);
    assign num      = (acc_reg > ssq_reg) ? acc_reg - ssq_reg : '0;

    // Restoring division, one quotient bit per cycle; quotient shifts into quo_reg.
    assign dpart = {drem_reg, quo_reg[psd_pkg::QUO_W-1]};
    assign dbit  = (dpart >= {1'b0, den_reg});

    // Digit-by-digit square root of quo_reg, two radicand bits per cycle.
    assign spart  = {srem_reg[psd_pkg::ROOT_W:0], quo_reg[psd_pkg::QUO_W-1 -: 2]};
    assign strial = {1'b0, root_reg, 2'b01};
    assign sbit   = (spart >= strial);

    always_ff @(posedge clk)
    begin
        if (cmd.mul_sq)
        begin
            ssq_reg <= psd_pkg::NUM_W'(prod);
            den_reg <= psd_pkg::DEN_W'(den_full);
        end
        if (cmd.mul_lo)
        begin
            acc_reg <= psd_pkg::NUM_W'(prod);
        end
        if (cmd.mul_hi)
        begin
            acc_reg <= acc_reg + {prod[psd_pkg::NUM_W-psd_pkg::SQ_HALF_W-1:0],
                                  {psd_pkg::SQ_HALF_W{1'b0}}};
        end
        if (cmd.div_init)
        begin
            quo_reg  <= {num, {(psd_pkg::QUO_W - psd_pkg::NUM_W){1'b0}}};
            drem_reg <= '0;
            root_reg <= '0;
            srem_reg <= '0;
        end
        if (cmd.div_step)
        begin
            drem_reg <= dbit ? psd_pkg::DEN_W'(dpart - {1'b0, den_reg})
                             : dpart[psd_pkg::DEN_W-1:0];
            quo_reg  <= {quo_reg[psd_pkg::QUO_W-2:0], dbit};
        end
        if (cmd.sqrt_step)
        begin
            srem_reg <= sbit ? (psd_pkg::ROOT_W+2)'(spart - strial)
                             : spart[psd_pkg::ROOT_W+1:0];
            root_reg <= {root_reg[psd_pkg::ROOT_W-2:0], sbit};
            quo_reg  <= {quo_reg[psd_pkg::QUO_W-3:0], 2'b00};
        end
    end

    assign sd_sat = (root_reg[psd_pkg::ROOT_W-1:psd_pkg::SD_W] != '0)
                    ? {psd_pkg::SD_W{1'b1}} : root_reg[psd_pkg::SD_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            std_dev_reg  <= (st_reg == psd_pkg::ST_OK) ? sd_sat : '0;
            last_out_reg <= last_reg;
            status_reg   <= st_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign std_dev    = std_dev_reg;
    assign last_pixel = last_out_reg;
    assign status     = status_reg;

endmodule

// ===== hw/rtl/pixelwise_std_deviation.sv =====
// Top level of the per-pixel sample standard deviation block.
// Depends on psd_pkg, psd_ctrl and psd_datapath.
//
// This block accumulates a running sum and sum of squares for every pixel position of a
// series of equal-size images (up to 4096 pixels, up to 256 images) and, on a readout
// transaction, returns the next pixel's sample standard deviation in unsigned Q16.8,
// saturated, with a last-pixel flag and a status (ok, fewer than two images, partial image).
// The block works on one transaction at a time. An add transaction makes a registered
// read of the pixel's store entries followed by the write-back of the sums. Clear and
// unused transactions, and adds to a full series, finish in the accepting cycle. A readout
// with a non-ok status goes straight to the output load; a readout with a valid result
// passes through acceptance, three shared-multiplier passes, a divider setup step, the
// bit-serial divider, the square root and the output load.
// A finished result sits in the output register, so the block returns to idle once it is free.
// The user must write pixel_count only while idle; the block itself does not enforce this.
module pixelwise_std_deviation
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write_en,
    input  logic [psd_pkg::PC_W-1:0]        cfg_write_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      action,
    input  logic [psd_pkg::SAMPLE_W-1:0]    sample,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [psd_pkg::SD_W-1:0]        std_dev,
    output logic                            last_pixel,
    output logic [1:0]                      status
);

    psd_pkg::cmd_t   cmd;
    psd_pkg::stat_t  stat;

    // The controller sequences each transaction through the datapath.
    psd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .action   (action),
        .in_stall (in_stall),
        .cmd      (cmd),
        .stat     (stat)
    );

    // The datapath holds the stores, the image and position counters and the arithmetic.
    psd_datapath u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .sample         (sample),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .std_dev        (std_dev),
        .last_pixel     (last_pixel),
        .status         (status)
    );

    // A result that is not ok always carries a zero deviation.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != psd_pkg::ST_OK)) |-> (std_dev == '0))
        else $error("non-ok result with nonzero deviation");

    // An accepted readout always keeps the block busy in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (action == psd_pkg::ACT_READ)) |=> in_stall)
        else $error("readout did not occupy the block");

    // An accepted add to a series that is not full takes a write-back cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (action == psd_pkg::ACT_ADD) && !stat.series_full)
        |=> (in_stall && cmd.acc_write))
        else $error("add transaction skipped its write-back");

endmodule
